FILE: sv/pfm_pkg.sv
// Shared types and constants for the pulse frequency meter.
`default_nettype none
package pfm_pkg;

	// Request kinds carried by an input item
	localparam logic REQ_PULSE = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT         = 2'd1;
	localparam int unsigned CFG_DATA_W = 16;

	// Register reset values
	localparam logic [15:0] UPDATE_INTERVAL_RST = 16'd200;
	localparam logic [15:0] TIMEOUT_RST         = 16'd1000;

	// Saturation limit for the speed
	localparam logic [15:0] SPEED_MAX = 16'hFFFF;

	// Restoring divider: one quotient bit per cycle
	localparam int unsigned DIV_W      = 32;
	localparam int unsigned DIV_CNT_W  = 5;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd31;

	typedef struct packed {
		logic        req_type;
		logic [31:0] now_ms;
		logic [31:0] now_us;
	} in_item_t;

	typedef struct packed {
		logic [15:0] speed;
		logic        updated;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic take;      // input item accepted this cycle
		logic div_step;  // shift in one quotient bit
		logic div_done;  // commit quotient and publish result
	} pfm_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic div_needed; // offered item is a read that recomputes the speed
		logic out_busy;   // output register holds an item not taken this cycle
	} pfm_sts_t;

endpackage
`default_nettype wire

FILE: sv/pfm_ctrl.sv
// Controller: sequences item acceptance and the iterative division.
`default_nettype none
module pfm_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire pfm_pkg::pfm_sts_t  sts,
	output pfm_pkg::pfm_cmd_t       cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic [pfm_pkg::DIV_CNT_W-1:0] step_q;

	assign in_ready = (state_q == S_IDLE) && !sts.out_busy;

	// Commands and next state
	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.take = in_valid && in_ready;
				if (cmd.take && sts.div_needed) begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == pfm_pkg::DIV_LAST) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.div_done = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIV) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/pfm_dp.sv
// Datapath: measurement state, config registers, divider and output register.
`default_nettype none
module pfm_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire pfm_pkg::in_item_t                 in_data,
	output pfm_pkg::out_item_t                     out_data,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	input  wire logic                              cfg_we,
	input  wire logic [pfm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [pfm_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire pfm_pkg::pfm_cmd_t                 cmd,
	output pfm_pkg::pfm_sts_t                      sts
);

	logic [15:0] interval_q;
	logic [15:0] timeout_q;
	logic [15:0] count_q;
	logic [31:0] last_pulse_q;
	logic [31:0] ref_pulse_q;
	logic [31:0] last_update_q;
	logic [15:0] speed_q;

	logic [pfm_pkg::DIV_W-1:0] rem_q;
	logic [pfm_pkg::DIV_W-1:0] quo_q;
	logic [pfm_pkg::DIV_W-1:0] den_q;

	logic                out_valid_q;
	pfm_pkg::out_item_t  out_q;

	logic        is_read;
	logic [31:0] elapsed;
	logic        interval_ok;
	logic        timed_out;
	logic        count_gt1;
	logic        big_count;
	logic [31:0] span;
	logic [31:0] num;
	logic [31:0] den;
	logic [15:0] speed_sat;

	logic [pfm_pkg::DIV_W:0] shifted;
	logic [pfm_pkg::DIV_W:0] trial;
	logic                    fits;

	// Decide what an offered read does
	always_comb begin
		is_read     = (in_data.req_type == pfm_pkg::REQ_READ);
		elapsed     = in_data.now_ms - last_update_q;
		interval_ok = elapsed > {16'd0, interval_q};
		timed_out   = elapsed > {16'd0, timeout_q};
		count_gt1   = count_q > 16'd1;
		big_count   = |count_q[15:8];
		span        = last_pulse_q - ref_pulse_q;
		num         = big_count ? {count_q, 16'd0} : {1'b0, count_q[7:0], 23'd0};
		den         = big_count ? {7'd0, span[31:7]} : span;
	end

	assign sts.div_needed = is_read && interval_ok && count_gt1;
	assign sts.out_busy   = out_valid_q && !out_ready;

	// One restoring division step
	always_comb begin
		shifted = {rem_q, quo_q[pfm_pkg::DIV_W-1]};
		trial   = shifted - {1'b0, den_q};
		fits    = shifted >= {1'b0, den_q};
	end

	// Quotient saturates to 16 bits; a zero divisor yields all ones
	assign speed_sat = (|quo_q[31:16]) ? pfm_pkg::SPEED_MAX : quo_q[15:0];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= pfm_pkg::UPDATE_INTERVAL_RST;
			timeout_q  <= pfm_pkg::TIMEOUT_RST;
		end else if (cfg_we) begin
			if (cfg_index == pfm_pkg::CFG_UPDATE_INTERVAL) begin
				interval_q <= cfg_data;
			end
			if (cfg_index == pfm_pkg::CFG_TIMEOUT) begin
				timeout_q <= cfg_data;
			end
		end
	end

	// Measurement state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			last_pulse_q  <= '0;
			ref_pulse_q   <= '0;
			last_update_q <= '0;
			speed_q       <= '0;
		end else if (cmd.take) begin
			if (!is_read) begin
				count_q      <= count_q + 16'd1;
				last_pulse_q <= in_data.now_us;
			end else if (interval_ok) begin
				if (count_gt1) begin
					count_q       <= '0;
					ref_pulse_q   <= last_pulse_q;
					last_update_q <= in_data.now_ms;
				end else if (timed_out) begin
					speed_q       <= '0;
					last_update_q <= in_data.now_ms;
				end
			end
		end else if (cmd.div_done) begin
			speed_q <= speed_sat;
		end
	end

	// Divider registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (cmd.div_step) begin
			rem_q <= fits ? trial[pfm_pkg::DIV_W-1:0] : shifted[pfm_pkg::DIV_W-1:0];
			quo_q <= {quo_q[pfm_pkg::DIV_W-2:0], fits};
		end
	end

	// Output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.take && !sts.div_needed) || cmd.div_done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (cmd.take && !sts.div_needed) begin
			if (is_read && interval_ok && timed_out) begin
				out_q.speed   <= '0;
				out_q.updated <= 1'b1;
			end else begin
				out_q.speed   <= speed_q;
				out_q.updated <= 1'b0;
			end
		end else if (cmd.div_done) begin
			out_q.speed   <= speed_sat;
			out_q.updated <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

FILE: sv/pulse_frequency_meter.sv
// Top level of the pulse frequency meter: controller plus datapath.
`default_nettype none
// Counts wheel pulse items and, on read items, recomputes a scaled pulse
// frequency at most once per update interval. Every item returns one result.
// A pulse item, or a read that does not divide, is answered straight from the
// output register. A read that recomputes the speed latches the operands,
// runs the one-bit-per-cycle restoring divider, then saturates and publishes.
// One item is in flight at a time; the output register lets a new item be
// accepted in the same cycle the previous result is taken. Configuration
// writes are taken at any time through cfg_we, cfg_index and cfg_data.
module pulse_frequency_meter (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire pfm_pkg::in_item_t               in_data,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output pfm_pkg::out_item_t                   out_data,
	input  wire logic                            cfg_we,
	input  wire logic [pfm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [pfm_pkg::CFG_DATA_W-1:0]  cfg_data
);

	pfm_pkg::pfm_cmd_t cmd;
	pfm_pkg::pfm_sts_t sts;

	pfm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pfm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
`default_nettype wire
